/* sv/wspr_pkg.sv */
package wspr_pkg;

  typedef struct packed {
    logic       found;
    logic [4:0] idx;
  } dbm_t;

  localparam logic signed [17:0] LOC_LIMIT = 18'sd4319;

  // Reciprocal multipliers: q = (x * MUL) >> SHIFT, exact over the operand width.
  localparam logic [30:0] DIV267_MUL   = 31'd2059010539;  // 30-bit operand
  localparam int          DIV267_SHIFT = 39;
  localparam logic [19:0] DIV3W_MUL    = 20'd699051;      // 19-bit operand
  localparam int          DIV3W_SHIFT  = 21;
  localparam logic [15:0] DIV3N_MUL    = 16'd43691;       // 15-bit operand
  localparam int          DIV3N_SHIFT  = 17;
  localparam logic [29:0] DIV21_MUL    = 30'd818089009;   // 29-bit operand
  localparam int          DIV21_SHIFT  = 34;
  localparam logic [22:0] DIV5_MUL     = 23'd6710887;     // 22-bit operand
  localparam int          DIV5_SHIFT   = 25;
  localparam logic [19:0] DIV45_MUL    = 20'd745655;      // 19-bit operand
  localparam int          DIV45_SHIFT  = 25;

  function automatic dbm_t dbm_index(input logic [5:0] p);
    dbm_t r;
    r.found = 1'b1;
    case (p)
      6'd0:    r.idx = 5'd0;
      6'd3:    r.idx = 5'd1;
      6'd7:    r.idx = 5'd2;
      6'd10:   r.idx = 5'd3;
      6'd13:   r.idx = 5'd4;
      6'd17:   r.idx = 5'd5;
      6'd20:   r.idx = 5'd6;
      6'd23:   r.idx = 5'd7;
      6'd27:   r.idx = 5'd8;
      6'd30:   r.idx = 5'd9;
      6'd33:   r.idx = 5'd10;
      6'd37:   r.idx = 5'd11;
      6'd40:   r.idx = 5'd12;
      6'd43:   r.idx = 5'd13;
      6'd47:   r.idx = 5'd14;
      6'd50:   r.idx = 5'd15;
      6'd53:   r.idx = 5'd16;
      6'd57:   r.idx = 5'd17;
      6'd60:   r.idx = 5'd18;
      default: begin
        r.idx   = 5'd0;
        r.found = 1'b0;
      end
    endcase
    return r;
  endfunction

  function automatic logic signed [13:0] loc_sat(input logic signed [17:0] v);
    logic signed [13:0] r;
    if (v > LOC_LIMIT) begin
      r = 14'(LOC_LIMIT);
    end else if (v < -LOC_LIMIT) begin
      r = 14'(-LOC_LIMIT);
    end else begin
      r = v[13:0];
    end
    return r;
  endfunction

  // Field index of a regular-grid letter, lower case folded.
  function automatic logic signed [17:0] grid_letter(input logic [7:0] c);
    logic signed [17:0] r;
    if (c >= 8'd97 && c <= 8'd122) begin
      r = $signed({10'd0, c}) - 18'sd97;
    end else begin
      r = $signed({10'd0, c}) - 18'sd65;
    end
    return r;
  endfunction

endpackage

/* sv/wspr_telemetry_decoder_top.sv */
// WSPR basic telemetry decoder.
// Input: present the telemetry callsign characters, the regular-message grid,
// the telemetry grid and the telemetry power on the in_ ports and raise start.
// A word is taken at every rising edge with start high and busy low; busy is
// always low, so a new word may be taken every cycle.
// Output: each decoded word appears on the out_ ports for exactly one cycle,
// flagged by out_valid, once it has passed through every register stage.
// Throughput is one word per cycle; there are six register stages: digit
// packing, three reciprocal-multiply divide stages (1068, 24, 24 on the callsign
// number; 42, 40, 90 on the grid/power number, one divide of each per stage),
// then latitude and longitude offset and saturation on the last two stages.
// Results leave in input order. The receiver cannot stall the block.
// Reset (rst_n low at a clock edge) clears every stage valid bit, dropping
// words in flight; the data registers are not reset.
module wspr_telemetry_decoder_top
  import wspr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        in_telem_call_chars,
  input  logic [31:0]        in_base_grid_chars,
  input  logic [31:0]        in_telem_grid_chars,
  input  logic [5:0]         in_telem_power_dbm,
  output logic               out_valid,
  output logic [14:0]        out_altitude_m,
  output logic [4:0]         out_subsq_lon,
  output logic [4:0]         out_subsq_lat,
  output logic signed [13:0] out_lat_48ths,
  output logic signed [13:0] out_lon_24ths,
  output logic               out_telem_flag,
  output logic               out_gps_valid,
  output logic [5:0]         out_speed_code,
  output logic [5:0]         out_voltage_code,
  output logic signed [6:0]  out_temperature_c,
  output logic               out_power_invalid
);

  logic [6:1] v_r, v_nxt;

  // stage 1
  logic [31:0]        x1_r, x1_nxt, x2_r, x2_nxt;
  logic signed [17:0] latp1_r, latp1_nxt, lonp1_r, lonp1_nxt;
  logic               pinv1_r, pinv1_nxt;
  // stage 2
  logic [21:0]        q1_2_r, q1_2_nxt;
  logic [10:0]        x1lo2_r;
  logic [1:0]         bits2_r;
  logic [5:0]         ylo2_r;
  logic [24:0]        qa2_r, qa2_nxt;
  logic signed [17:0] latp2_r, lonp2_r;
  logic               pinv2_r;
  // stage 3
  logic [14:0]        alt3_r, alt3_nxt;
  logic [4:0]         q1lo3_r;
  logic [17:0]        q2_3_r, q2_3_nxt;
  logic [5:0]         spd3_r, spd3_nxt, qalo3_r;
  logic [1:0]         bits3_r;
  logic [19:0]        qb3_r, qb3_nxt;
  logic signed [17:0] latp3_r, lonp3_r;
  logic               pinv3_r;
  // stage 4
  logic [14:0]        alt4_r;
  logic [4:0]         slat4_r, slat4_nxt, q2lo4_r;
  logic [13:0]        q3_4_r, q3_4_nxt;
  logic [5:0]         spd4_r, volt4_r, volt4_nxt;
  logic [1:0]         bits4_r;
  logic [6:0]         qblo4_r;
  logic [13:0]        qc4_r, qc4_nxt;
  logic signed [17:0] latp4_r, lonp4_r;
  logic               pinv4_r;
  // stage 5
  logic [14:0]        alt5_r;
  logic [4:0]         slat5_r, slon5_r, slon5_nxt;
  logic signed [13:0] lat5_r, lat5_nxt;
  logic signed [17:0] lonp5_r;
  logic [5:0]         spd5_r, volt5_r;
  logic [1:0]         bits5_r;
  logic signed [6:0]  temp5_r, temp5_nxt;
  logic               pinv5_r;
  // stage 6
  logic [14:0]        alt6_r;
  logic [4:0]         slat6_r, slon6_r;
  logic signed [13:0] lat6_r, lon6_r, lon6_nxt;
  logic [5:0]         spd6_r, volt6_r;
  logic [1:0]         bits6_r;
  logic signed [6:0]  temp6_r;
  logic               pinv6_r;

  // stage 1: digit packing, grid field/square, power index
  always_comb begin
    logic [7:0]  c1;
    logic [31:0] d0, d1, d2, d3, t0, t1, t2, t3;
    dbm_t        pw;
    c1 = in_telem_call_chars[31:24];
    d0 = (c1 < 8'd65) ? ({24'd0, c1} - 32'd48) : ({24'd0, c1} - 32'd55);
    d1 = {24'd0, in_telem_call_chars[23:16]} - 32'd65;
    d2 = {24'd0, in_telem_call_chars[15:8]}  - 32'd65;
    d3 = {24'd0, in_telem_call_chars[7:0]}   - 32'd65;
    x1_nxt = d0 * 32'd17576 + d1 * 32'd676 + d2 * 32'd26 + d3;

    pw = dbm_index(in_telem_power_dbm);
    pinv1_nxt = ~pw.found;
    t0 = {24'd0, in_telem_grid_chars[31:24]} - 32'd65;
    t1 = {24'd0, in_telem_grid_chars[23:16]} - 32'd65;
    t2 = {24'd0, in_telem_grid_chars[15:8]}  - 32'd48;
    t3 = {24'd0, in_telem_grid_chars[7:0]}   - 32'd48;
    x2_nxt = t0 * 32'd34200 + t1 * 32'd1900 + t2 * 32'd190 + t3 * 32'd19
           + {27'd0, pw.idx};

    lonp1_nxt = grid_letter(in_base_grid_chars[31:24]) * 18'sd480
              + ($signed({10'd0, in_base_grid_chars[15:8]}) - 18'sd48) * 18'sd48
              - 18'sd4319;
    latp1_nxt = grid_letter(in_base_grid_chars[23:16]) * 18'sd480
              + ($signed({10'd0, in_base_grid_chars[7:0]}) - 18'sd48) * 18'sd48
              - 18'sd4319;
  end

  // stage 2: first divide of each packed number
  always_comb begin
    logic [60:0] p1;
    logic [58:0] p2;
    p1 = 61'(x1_r[31:2]) * 61'(DIV267_MUL);
    q1_2_nxt = p1[DIV267_SHIFT +: 22];
    p2 = 59'(x2_r[31:3]) * 59'(DIV21_MUL);
    qa2_nxt = p2[DIV21_SHIFT +: 25];
  end

  // stage 3: remainders of the first divides, second divides
  always_comb begin
    logic [10:0] r1;
    logic [38:0] p1;
    logic [44:0] p2;
    r1 = x1lo2_r - 11'(q1_2_r * 22'd1068);
    alt3_nxt = 15'(r1) * 15'd20;
    p1 = 39'(q1_2_r[21:3]) * 39'(DIV3W_MUL);
    q2_3_nxt = p1[DIV3W_SHIFT +: 18];
    spd3_nxt = ylo2_r - 6'(qa2_r * 25'd42);
    p2 = 45'(qa2_r[24:3]) * 45'(DIV5_MUL);
    qb3_nxt = p2[DIV5_SHIFT +: 20];
  end

  // stage 4
  always_comb begin
    logic [30:0] p1;
    logic [38:0] p2;
    slat4_nxt = q1lo3_r - 5'(q2_3_r * 18'd24);
    p1 = 31'(q2_3_r[17:3]) * 31'(DIV3N_MUL);
    q3_4_nxt = p1[DIV3N_SHIFT +: 14];
    volt4_nxt = qalo3_r - 6'(qb3_r * 20'd40);
    p2 = 39'(qb3_r[19:1]) * 39'(DIV45_MUL);
    qc4_nxt = p2[DIV45_SHIFT +: 14];
  end

  // stage 5
  always_comb begin
    logic [6:0] tr;
    slon5_nxt = q2lo4_r - 5'(q3_4_r * 14'd24);
    lat5_nxt  = loc_sat(latp4_r + $signed({12'd0, slat4_r, 1'b0}));
    tr        = qblo4_r - 7'(qc4_r * 14'd90);
    temp5_nxt = $signed(tr - 7'd50);
  end

  // stage 6
  always_comb begin
    lon6_nxt = loc_sat(lonp5_r + $signed({12'd0, slon5_r, 1'b0}));
  end

  always_comb begin
    v_nxt = {v_r[5:1], start & ~busy};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x1_r    <= x1_nxt;
    x2_r    <= x2_nxt;
    latp1_r <= latp1_nxt;
    lonp1_r <= lonp1_nxt;
    pinv1_r <= pinv1_nxt;

    q1_2_r  <= q1_2_nxt;
    x1lo2_r <= x1_r[10:0];
    bits2_r <= x2_r[1:0];
    ylo2_r  <= x2_r[7:2];
    qa2_r   <= qa2_nxt;
    latp2_r <= latp1_r;
    lonp2_r <= lonp1_r;
    pinv2_r <= pinv1_r;

    alt3_r  <= alt3_nxt;
    q1lo3_r <= q1_2_r[4:0];
    q2_3_r  <= q2_3_nxt;
    spd3_r  <= spd3_nxt;
    qalo3_r <= qa2_r[5:0];
    bits3_r <= bits2_r;
    qb3_r   <= qb3_nxt;
    latp3_r <= latp2_r;
    lonp3_r <= lonp2_r;
    pinv3_r <= pinv2_r;

    alt4_r  <= alt3_r;
    slat4_r <= slat4_nxt;
    q2lo4_r <= q2_3_r[4:0];
    q3_4_r  <= q3_4_nxt;
    spd4_r  <= spd3_r;
    volt4_r <= volt4_nxt;
    bits4_r <= bits3_r;
    qblo4_r <= qb3_r[6:0];
    qc4_r   <= qc4_nxt;
    latp4_r <= latp3_r;
    lonp4_r <= lonp3_r;
    pinv4_r <= pinv3_r;

    alt5_r  <= alt4_r;
    slat5_r <= slat4_r;
    slon5_r <= slon5_nxt;
    lat5_r  <= lat5_nxt;
    lonp5_r <= lonp4_r;
    spd5_r  <= spd4_r;
    volt5_r <= volt4_r;
    bits5_r <= bits4_r;
    temp5_r <= temp5_nxt;
    pinv5_r <= pinv4_r;

    alt6_r  <= alt5_r;
    slat6_r <= slat5_r;
    slon6_r <= slon5_r;
    lat6_r  <= lat5_r;
    lon6_r  <= lon6_nxt;
    spd6_r  <= spd5_r;
    volt6_r <= volt5_r;
    bits6_r <= bits5_r;
    temp6_r <= temp5_r;
    pinv6_r <= pinv5_r;
  end

  assign busy              = 1'b0;
  assign out_valid         = v_r[6];
  assign out_altitude_m    = alt6_r;
  assign out_subsq_lon     = slon6_r;
  assign out_subsq_lat     = slat6_r;
  assign out_lat_48ths     = lat6_r;
  assign out_lon_24ths     = lon6_r;
  assign out_telem_flag    = bits6_r[0];
  assign out_gps_valid     = bits6_r[1];
  assign out_speed_code    = spd6_r;
  assign out_voltage_code  = volt6_r;
  assign out_temperature_c = temp6_r;
  assign out_power_invalid = pinv6_r;

endmodule
